### src/nfc_type4_tag_apdu_responder_assert.svh
// Assertion macros for the type 4 tag responder.
// Included by the top level; no other dependencies.
`ifndef NFC_TYPE4_TAG_APDU_RESPONDER_ASSERT_SVH
`define NFC_TYPE4_TAG_APDU_RESPONDER_ASSERT_SVH

// a holds at this edge -> c holds at this edge
`define NT4_ASSERT_NOW(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("nt4 assertion failed");

// a holds at this edge -> c holds at the next edge
`define NT4_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("nt4 assertion failed");

`endif

### src/nt4_pkg.sv
// Shared types, constants and lookup functions of the type 4 tag responder.
// No dependencies.
package nt4_pkg;

  localparam int CC_DEPTH_DEF    = 16;
  localparam int NDEF_DEPTH_DEF  = 1024;
  localparam int WRITE_DEPTH_DEF = 1024;

  localparam int BYTE_W     = 8;
  localparam int ADDR_W     = 10;
  localparam int POS_W      = 9;
  localparam int OPND_W     = 17;
  localparam int LIMIT_W    = 11;
  localparam int CAP_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int HDR_LEN    = 5;
  localparam int HDR_IDX_W  = 3;

  localparam logic [POS_W-1:0]   POS_MAX       = 9'd511;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 11'd1024;
  localparam logic [CAP_W-1:0]   CAP_MAX       = 7'd64;

  localparam logic [BYTE_W-1:0] INS_SELECT  = 8'hA4;
  localparam logic [BYTE_W-1:0] INS_READ    = 8'hB0;
  localparam logic [BYTE_W-1:0] INS_UPDATE  = 8'hD6;
  localparam logic [BYTE_W-1:0] P1_BY_ID    = 8'h00;
  localparam logic [BYTE_W-1:0] P1_BY_NAME  = 8'h04;
  localparam logic [BYTE_W-1:0] P2_ID_MASK  = 8'h0C;
  localparam logic [BYTE_W-1:0] SW_OK_HI    = 8'h90;
  localparam logic [BYTE_W-1:0] SW_OK_LO    = 8'h00;
  localparam logic [BYTE_W-1:0] SW_ERR_HI   = 8'h6A;
  localparam logic [BYTE_W-1:0] SW_WRONG_LO = 8'h00;
  localparam logic [BYTE_W-1:0] SW_NF_LO    = 8'h82;
  localparam logic [BYTE_W-1:0] ID_LEN      = 8'd2;
  localparam logic [BYTE_W-1:0] NAME_LEN    = 8'd7;

  typedef enum logic [1:0] {
    FUNC_APDU, FUNC_LOAD_CC, FUNC_LOAD_NDEF, FUNC_READBACK
  } func_t;

  typedef enum logic [1:0] {FILE_NONE, FILE_CC, FILE_NDEF} file_t;

  typedef enum logic [1:0] {FAULT_NONE, FAULT_PROTOCOL, FAULT_CAPACITY} fault_t;

  typedef enum logic [1:0] {OC_FAULT, OC_STATUS, OC_READ} outcome_t;

  typedef enum logic [2:0] {EM_FAULT, EM_SW1, EM_SW2, EM_DATA, EM_READBACK} emit_t;

  typedef enum logic [CFG_IDX_W-1:0] {REG_WRITE_LIMIT, REG_RESP_CAP} cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISPATCH, ST_MOD, ST_STORE, ST_FINISH, ST_RD_MOD, ST_RD_ISSUE,
    ST_RD_WAIT, ST_SW1, ST_SW2, ST_FAULT, ST_RB_ISSUE, ST_RB_WAIT
  } state_t;

  typedef struct packed {
    logic  accept;
    logic  take_byte;
    logic  mod_start;
    logic  mod_read;
    logic  store;
    logic  finish;
    logic  rd_en;
    logic  rd_from_mod;
    logic  cnt_dec;
    logic  emit;
    emit_t emit_sel;
  } ctl_t;

  typedef struct packed {
    func_t    func;
    logic     apdu_end;
    logic     need_write;
    outcome_t outcome;
    logic     lc_zero;
    logic     mod_busy;
    logic     out_free;
    logic     cnt_last;
  } stat_t;

  function automatic logic [BYTE_W-1:0] id_cc_byte(input logic [0:0] k);
    return k[0] ? 8'h03 : 8'hE1;
  endfunction

  function automatic logic [BYTE_W-1:0] id_ndef_byte(input logic [0:0] k);
    return k[0] ? 8'h04 : 8'hE1;
  endfunction

  function automatic logic [BYTE_W-1:0] app_name_byte(input logic [2:0] k);
    logic [BYTE_W-1:0] b;
    case (k)
      3'd0: b = 8'hD2;
      3'd1: b = 8'h76;
      3'd2: b = 8'h00;
      3'd3: b = 8'h00;
      3'd4: b = 8'h85;
      3'd5: b = 8'h01;
      3'd6: b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### src/nfc_type4_tag_apdu_responder.sv
// Top level of the NFC type 4 tag command responder: controller plus datapath.
// Depends on nt4_pkg, nt4_ctrl, nt4_dp and the assertion macro header.
//
//  channel  direction  handshake             payload
//  cmd      in         cmd_valid/cmd_stall   func byte_value apdu_end store_address
//  rsp      out        rsp_valid/rsp_stall   response_byte response_end fault phone_wrote
//  cfg      in         cfg_valid/cfg_ready   cfg_index cfg_data
//
// A command byte is accepted, then dispatched; a stored byte (load, update data) passes
// the two-bit-per-cycle remainder unit and a RAM write. The last byte adds decode, then
// a read adds the remainder, a RAM read, LC data bytes and two status bytes, one byte a
// cycle unless stalled. Reset is synchronous and leaves the stores as they were.
// A stalled response holds in the output register; the controller waits on it.
`include "nfc_type4_tag_apdu_responder_assert.svh"

module nfc_type4_tag_apdu_responder #(
  parameter int CC_DEPTH    = nt4_pkg::CC_DEPTH_DEF,
  parameter int NDEF_DEPTH  = nt4_pkg::NDEF_DEPTH_DEF,
  parameter int WRITE_DEPTH = nt4_pkg::WRITE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_stall,
  input  logic [1:0]                     func,
  input  logic [nt4_pkg::BYTE_W-1:0]     byte_value,
  input  logic                           apdu_end,
  input  logic [nt4_pkg::ADDR_W-1:0]     store_address,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic [nt4_pkg::BYTE_W-1:0]     response_byte,
  output logic                           response_end,
  output logic [1:0]                     fault,
  output logic                           phone_wrote,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [nt4_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nt4_pkg::CFG_DATA_W-1:0] cfg_data
);
  import nt4_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  nt4_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  nt4_dp #(
    .CC_DEPTH    (CC_DEPTH),
    .NDEF_DEPTH  (NDEF_DEPTH),
    .WRITE_DEPTH (WRITE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .stat          (stat),
    .func          (func),
    .byte_value    (byte_value),
    .apdu_end      (apdu_end),
    .store_address (store_address),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .response_byte (response_byte),
    .response_end  (response_end),
    .fault         (fault),
    .phone_wrote   (phone_wrote)
  );

  `NT4_ASSERT_NEXT(a_busy_after_accept, clk, rst, cmd_valid && !cmd_stall, cmd_stall)
  `NT4_ASSERT_NOW(a_fault_single, clk, rst, rsp_valid && fault != 2'd0, response_end && response_byte == '0 && !phone_wrote)
  `NT4_ASSERT_NOW(a_mod_idle_on_start, clk, rst, ctl.mod_start, !stat.mod_busy)
  `NT4_ASSERT_NOW(a_emit_when_free, clk, rst, ctl.emit, stat.out_free)

endmodule

### src/nt4_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module nt4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/nt4_mod.sv
// Iterative remainder unit: operand modulo a divisor, two bits per cycle.
// Depends on nt4_pkg.
module nt4_mod #(
  parameter int RW = 11
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [nt4_pkg::OPND_W-1:0] operand,
  input  logic [RW-1:0]             divisor,
  output logic                      busy,
  output logic [RW-1:0]             rem
);
  import nt4_pkg::*;

  localparam int STEPS = (OPND_W + 1) / 2;
  localparam int SH_W  = 2 * STEPS;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [SH_W-1:0]  sh;
  logic [RW-1:0]    dv;
  logic [RW-1:0]    r;
  logic [CNT_W-1:0] cnt;
  logic [RW-1:0]    r1;
  logic [RW-1:0]    r2;

  always_comb begin
    r1 = {r[RW-2:0], sh[SH_W-1]};
    if (r1 >= dv) begin
      r1 = r1 - dv;
    end
    r2 = {r1[RW-2:0], sh[SH_W-2]};
    if (r2 >= dv) begin
      r2 = r2 - dv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(STEPS);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh <= SH_W'(operand);
      dv <= divisor;
      r  <= '0;
    end else if (busy) begin
      sh <= {sh[SH_W-3:0], 2'b00};
      r  <= r2;
    end
  end

  assign rem = r;

endmodule

### src/nt4_dp.sv
// Datapath of the type 4 tag responder: header parse, stores, remainder
// unit, response register and configuration. Depends on nt4_pkg, nt4_ram, nt4_mod.
module nt4_dp #(
  parameter int CC_DEPTH    = nt4_pkg::CC_DEPTH_DEF,
  parameter int NDEF_DEPTH  = nt4_pkg::NDEF_DEPTH_DEF,
  parameter int WRITE_DEPTH = nt4_pkg::WRITE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  nt4_pkg::ctl_t                 ctl,
  output nt4_pkg::stat_t                stat,
  input  logic [1:0]                    func,
  input  logic [nt4_pkg::BYTE_W-1:0]    byte_value,
  input  logic                          apdu_end,
  input  logic [nt4_pkg::ADDR_W-1:0]    store_address,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [nt4_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nt4_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [nt4_pkg::BYTE_W-1:0]    response_byte,
  output logic                          response_end,
  output logic [1:0]                    fault,
  output logic                          phone_wrote
);
  import nt4_pkg::*;

  localparam int MAX_CN  = (CC_DEPTH > NDEF_DEPTH) ? CC_DEPTH : NDEF_DEPTH;
  localparam int MAX_D   = (MAX_CN > WRITE_DEPTH) ? MAX_CN : WRITE_DEPTH;
  localparam int PW      = $clog2(MAX_D);
  localparam int RW      = PW + 1;
  localparam int CC_AW   = $clog2(CC_DEPTH);
  localparam int NDEF_AW = $clog2(NDEF_DEPTH);
  localparam int WR_AW   = $clog2(WRITE_DEPTH);

  localparam logic [RW-1:0] CC_DIV   = RW'(CC_DEPTH);
  localparam logic [RW-1:0] NDEF_DIV = RW'(NDEF_DEPTH);
  localparam logic [RW-1:0] WR_DIV   = RW'(WRITE_DEPTH);
  localparam logic [PW-1:0] CC_LAST   = PW'(CC_DEPTH - 1);
  localparam logic [PW-1:0] NDEF_LAST = PW'(NDEF_DEPTH - 1);
  localparam logic [PW-1:0] WR_LAST   = PW'(WRITE_DEPTH - 1);

  func_t              func_r;
  logic [BYTE_W-1:0]  byte_r;
  logic               end_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [LIMIT_W-1:0] write_limit;
  logic [CAP_W-1:0]   resp_cap;
  file_t              sel;
  logic [BYTE_W-1:0]  hdr [HDR_LEN];
  logic [POS_W-1:0]   pos;
  logic               cmp_ok;
  logic               ndef_ok;
  fault_t             oc_fault;
  logic [BYTE_W-1:0]  sw1;
  logic [BYTE_W-1:0]  sw2;
  logic               phone;
  logic [BYTE_W-1:0]  cnt;
  logic [PW-1:0]      rd_ptr;

  logic [BYTE_W-1:0]  ins, p1, p2, lc_raw, lc;
  logic [15:0]        base;
  logic               pos_hdr;
  logic [POS_W-1:0]   k;
  logic               in_data;
  logic               fits;
  logic               need_write;

  outcome_t           fo_kind;
  fault_t             fo_fault;
  logic [BYTE_W-1:0]  fo_sw1, fo_sw2;
  logic               fo_phone;
  logic               fo_sel_wr;
  file_t              fo_sel;
  logic [CAP_W-1:0]   cap;

  logic [OPND_W-1:0]  mod_opnd;
  logic [RW-1:0]      mod_div;
  logic               mod_busy;
  logic [RW-1:0]      rem;

  logic [PW-1:0]      raddr;
  logic [PW-1:0]      last;
  logic [BYTE_W-1:0]  cc_rdata, ndef_rdata, wr_rdata, rdata;
  logic               out_free;

  assign ins    = hdr[1];
  assign p1     = hdr[2];
  assign p2     = hdr[3];
  assign lc_raw = hdr[4];
  assign base   = {p1, p2};

  assign pos_hdr    = pos < POS_W'(HDR_LEN);
  assign k          = pos - POS_W'(HDR_LEN);
  assign in_data    = !pos_hdr && (hdr[0] == '0) && (k < POS_W'(lc_raw));
  assign fits       = (OPND_W'(base) + OPND_W'(lc_raw)) <= OPND_W'(write_limit);
  assign need_write = in_data && (ins == INS_UPDATE) && fits;
  assign lc         = pos_hdr ? '0 : lc_raw;
  assign cap        = (resp_cap > CAP_MAX) ? CAP_MAX : resp_cap;

  // command decode on the last byte
  always_comb begin
    fo_kind   = OC_FAULT;
    fo_fault  = FAULT_PROTOCOL;
    fo_sw1    = SW_OK_HI;
    fo_sw2    = SW_OK_LO;
    fo_phone  = 1'b0;
    fo_sel_wr = 1'b0;
    fo_sel    = FILE_NONE;
    if (pos < POS_W'(4) || hdr[0] != '0) begin
      fo_kind = OC_FAULT;
    end else if (ins == INS_SELECT) begin
      if (p1 == P1_BY_ID) begin
        if ((p2 | P2_ID_MASK) == P2_ID_MASK) begin
          fo_kind   = OC_STATUS;
          fo_sel_wr = 1'b1;
          if (lc == ID_LEN && pos >= POS_W'(7) && cmp_ok) begin
            fo_sel = FILE_CC;
          end else if (lc == ID_LEN && pos >= POS_W'(7) && ndef_ok) begin
            fo_sel = FILE_NDEF;
          end else begin
            fo_sel = FILE_NONE;
            fo_sw1 = SW_ERR_HI;
            fo_sw2 = SW_WRONG_LO;
          end
        end
      end else if (p1 == P1_BY_NAME) begin
        if (p2 == '0) begin
          fo_kind = OC_STATUS;
          if (!(lc == NAME_LEN && pos >= POS_W'(12) && cmp_ok)) begin
            fo_sw1 = SW_ERR_HI;
            fo_sw2 = SW_NF_LO;
          end
        end
      end
    end else if (ins == INS_READ) begin
      if ((9'(lc) + 9'd2) > 9'(cap)) begin
        fo_fault = FAULT_CAPACITY;
      end else if (sel == FILE_CC || sel == FILE_NDEF) begin
        fo_kind = OC_READ;
      end else begin
        fo_kind = OC_STATUS;
        fo_sw1  = SW_ERR_HI;
        fo_sw2  = SW_NF_LO;
      end
    end else if (ins == INS_UPDATE) begin
      fo_kind  = OC_STATUS;
      fo_phone = (lc == ID_LEN);
    end
  end

  always_comb begin
    mod_opnd = OPND_W'(addr_r);
    mod_div  = WR_DIV;
    case (func_r)
      FUNC_LOAD_CC: begin
        mod_div = CC_DIV;
      end
      FUNC_LOAD_NDEF: begin
        mod_div = NDEF_DIV;
      end
      FUNC_READBACK: begin
        mod_div = WR_DIV;
      end
      FUNC_APDU: begin
        if (ctl.mod_read) begin
          mod_opnd = OPND_W'(base);
          mod_div  = (sel == FILE_CC) ? CC_DIV : NDEF_DIV;
        end else begin
          mod_opnd = OPND_W'(base) + OPND_W'(k[BYTE_W-1:0]);
          mod_div  = WR_DIV;
        end
      end
      default: begin
        mod_div = WR_DIV;
      end
    endcase
  end

  nt4_mod #(.RW(RW)) u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (ctl.mod_start),
    .operand (mod_opnd),
    .divisor (mod_div),
    .busy    (mod_busy),
    .rem     (rem)
  );

  always_comb begin
    if (func_r == FUNC_READBACK) begin
      rdata = wr_rdata;
      last  = WR_LAST;
    end else if (sel == FILE_CC) begin
      rdata = cc_rdata;
      last  = CC_LAST;
    end else begin
      rdata = ndef_rdata;
      last  = NDEF_LAST;
    end
  end

  assign raddr = ctl.rd_from_mod ? rem[PW-1:0] : rd_ptr;

  nt4_ram #(.WIDTH(BYTE_W), .DEPTH(CC_DEPTH)) u_cc_ram (
    .clk   (clk),
    .we    (ctl.store && func_r == FUNC_LOAD_CC),
    .waddr (rem[CC_AW-1:0]),
    .wdata (byte_r),
    .re    (ctl.rd_en),
    .raddr (raddr[CC_AW-1:0]),
    .rdata (cc_rdata)
  );

  nt4_ram #(.WIDTH(BYTE_W), .DEPTH(NDEF_DEPTH)) u_ndef_ram (
    .clk   (clk),
    .we    (ctl.store && func_r == FUNC_LOAD_NDEF),
    .waddr (rem[NDEF_AW-1:0]),
    .wdata (byte_r),
    .re    (ctl.rd_en),
    .raddr (raddr[NDEF_AW-1:0]),
    .rdata (ndef_rdata)
  );

  nt4_ram #(.WIDTH(BYTE_W), .DEPTH(WRITE_DEPTH)) u_wr_ram (
    .clk   (clk),
    .we    (ctl.store && func_r == FUNC_APDU),
    .waddr (rem[WR_AW-1:0]),
    .wdata (byte_r),
    .re    (ctl.rd_en),
    .raddr (raddr[WR_AW-1:0]),
    .rdata (wr_rdata)
  );

  assign out_free = !rsp_valid || !rsp_stall;

  always_comb begin
    stat.func       = func_r;
    stat.apdu_end   = end_r;
    stat.need_write = need_write;
    stat.outcome    = fo_kind;
    stat.lc_zero    = (lc == '0);
    stat.mod_busy   = mod_busy;
    stat.out_free   = out_free;
    stat.cnt_last   = (cnt == BYTE_W'(1));
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_limit <= LIMIT_RESET;
      resp_cap    <= CAP_MAX;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_WRITE_LIMIT: write_limit <= cfg_data[LIMIT_W-1:0];
        REG_RESP_CAP:    resp_cap    <= cfg_data[CAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      func_r <= func_t'(func);
      byte_r <= byte_value;
      end_r  <= apdu_end;
      addr_r <= store_address;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      sel     <= FILE_NONE;
      pos     <= '0;
      cmp_ok  <= 1'b1;
      ndef_ok <= 1'b1;
      for (int i = 0; i < HDR_LEN; i++) begin
        hdr[i] <= '0;
      end
    end else if (ctl.finish) begin
      if (fo_sel_wr) begin
        sel <= fo_sel;
      end
      pos     <= '0;
      cmp_ok  <= 1'b1;
      ndef_ok <= 1'b1;
      for (int i = 0; i < HDR_LEN; i++) begin
        hdr[i] <= '0;
      end
    end else if (ctl.take_byte) begin
      if (pos_hdr) begin
        hdr[pos[HDR_IDX_W-1:0]] <= byte_r;
      end else if (in_data && ins == INS_SELECT) begin
        if (p1 == P1_BY_ID) begin
          if (k < POS_W'(ID_LEN)) begin
            if (byte_r != id_cc_byte(k[0:0])) begin
              cmp_ok <= 1'b0;
            end
            if (byte_r != id_ndef_byte(k[0:0])) begin
              ndef_ok <= 1'b0;
            end
          end
        end else if (k < POS_W'(NAME_LEN) && byte_r != app_name_byte(k[2:0])) begin
          cmp_ok <= 1'b0;
        end
      end
      if (pos != POS_MAX) begin
        pos <= pos + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      oc_fault <= fo_fault;
      sw1      <= fo_sw1;
      sw2      <= fo_sw2;
      phone    <= fo_phone;
      cnt      <= lc;
    end else if (ctl.cnt_dec) begin
      cnt <= cnt - BYTE_W'(1);
    end
    if (ctl.rd_en) begin
      rd_ptr <= (raddr == last) ? '0 : raddr + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      case (ctl.emit_sel)
        EM_FAULT: begin
          response_byte <= '0;
          response_end  <= 1'b1;
          fault         <= oc_fault;
          phone_wrote   <= 1'b0;
        end
        EM_SW1: begin
          response_byte <= sw1;
          response_end  <= 1'b0;
          fault         <= FAULT_NONE;
          phone_wrote   <= phone;
        end
        EM_SW2: begin
          response_byte <= sw2;
          response_end  <= 1'b1;
          fault         <= FAULT_NONE;
          phone_wrote   <= phone;
        end
        EM_DATA: begin
          response_byte <= rdata;
          response_end  <= 1'b0;
          fault         <= FAULT_NONE;
          phone_wrote   <= 1'b0;
        end
        default: begin
          response_byte <= rdata;
          response_end  <= 1'b1;
          fault         <= FAULT_NONE;
          phone_wrote   <= 1'b0;
        end
      endcase
    end
  end

endmodule

### src/nt4_ctrl.sv
// Controller state machine of the type 4 tag responder.
// Depends on nt4_pkg; drives the datapath through ctl_t, reads stat_t.
module nt4_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  nt4_pkg::stat_t stat,
  output nt4_pkg::ctl_t  ctl
);
  import nt4_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.emit_sel = EM_FAULT;
    cmd_stall  = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          ctl.accept = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (stat.func == FUNC_APDU) begin
          ctl.take_byte = 1'b1;
          if (stat.need_write) begin
            ctl.mod_start = 1'b1;
            state_next    = ST_MOD;
          end else if (stat.apdu_end) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_IDLE;
          end
        end else begin
          ctl.mod_start = 1'b1;
          state_next    = ST_MOD;
        end
      end
      ST_MOD: begin
        if (!stat.mod_busy) begin
          state_next = (stat.func == FUNC_READBACK) ? ST_RB_ISSUE : ST_STORE;
        end
      end
      ST_STORE: begin
        ctl.store  = 1'b1;
        state_next = (stat.func == FUNC_APDU && stat.apdu_end) ? ST_FINISH : ST_IDLE;
      end
      ST_FINISH: begin
        ctl.finish = 1'b1;
        case (stat.outcome)
          OC_STATUS: state_next = ST_SW1;
          OC_READ: begin
            if (stat.lc_zero) begin
              state_next = ST_SW1;
            end else begin
              ctl.mod_start = 1'b1;
              ctl.mod_read  = 1'b1;
              state_next    = ST_RD_MOD;
            end
          end
          default: state_next = ST_FAULT;
        endcase
      end
      ST_RD_MOD: begin
        if (!stat.mod_busy) begin
          state_next = ST_RD_ISSUE;
        end
      end
      ST_RD_ISSUE: begin
        ctl.rd_en       = 1'b1;
        ctl.rd_from_mod = 1'b1;
        state_next      = ST_RD_WAIT;
      end
      ST_RD_WAIT: begin
        if (stat.out_free) begin
          ctl.emit     = 1'b1;
          ctl.emit_sel = EM_DATA;
          ctl.cnt_dec  = 1'b1;
          if (stat.cnt_last) begin
            state_next = ST_SW1;
          end else begin
            ctl.rd_en = 1'b1;
          end
        end
      end
      ST_SW1: begin
        if (stat.out_free) begin
          ctl.emit     = 1'b1;
          ctl.emit_sel = EM_SW1;
          state_next   = ST_SW2;
        end
      end
      ST_SW2: begin
        if (stat.out_free) begin
          ctl.emit     = 1'b1;
          ctl.emit_sel = EM_SW2;
          state_next   = ST_IDLE;
        end
      end
      ST_FAULT: begin
        if (stat.out_free) begin
          ctl.emit     = 1'b1;
          ctl.emit_sel = EM_FAULT;
          state_next   = ST_IDLE;
        end
      end
      ST_RB_ISSUE: begin
        ctl.rd_en       = 1'b1;
        ctl.rd_from_mod = 1'b1;
        state_next      = ST_RB_WAIT;
      end
      ST_RB_WAIT: begin
        if (stat.out_free) begin
          ctl.emit     = 1'b1;
          ctl.emit_sel = EM_READBACK;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
